// File: hdl/ccw_pkg.sv
// ============================================================================
// ccw_pkg - shared types and constants of the coin change way counter
// Field widths, request/response packing, microcode word and status types.
// ============================================================================
package ccw_pkg;

   // field widths
   localparam int AMOUNT_W    = 10;
   localparam int KINDS_W     = 8;
   localparam int DENOM_W     = 10;
   localparam int WAYS_W      = 48;
   localparam int CSR_IDX_W   = 3;

   // request packing: amount in the low bits, then coin_kinds
   localparam int REQ_AMOUNT_LSB = 0;
   localparam int REQ_KINDS_LSB  = AMOUNT_W;
   localparam int REQ_TDATA_W    = 24;
   localparam int RSP_TDATA_W    = 48;

   // reset denominations, one per coin kind
   localparam logic [DENOM_W-1:0] DENOM_RESET [8] = '{
      10'd1, 10'd2, 10'd3, 10'd20, 10'd25, 10'd50, 10'd0, 10'd0
   };

   // microcode addresses
   typedef enum logic [2:0] {
      STEP_IDLE   = 3'd0,
      STEP_CHECK  = 3'd1,
      STEP_CLEAR  = 3'd2,
      STEP_KIND   = 3'd3,
      STEP_SETUP  = 3'd4,
      STEP_LOOP   = 3'd5,
      STEP_FETCH  = 3'd6,
      STEP_RESULT = 3'd7
   } step_type;

   // branch condition selector
   typedef enum logic [2:0] {
      COND_REQ        = 3'd0,
      COND_IMPROPER   = 3'd1,
      COND_CLEAR_END  = 3'd2,
      COND_KINDS_DONE = 3'd3,
      COND_SKIP       = 3'd4,
      COND_LOOP_DONE  = 3'd5,
      COND_ALWAYS     = 3'd6,
      COND_RSP_FREE   = 3'd7
   } cond_type;

   typedef enum logic [1:0] {
      WR_NONE        = 2'd0,
      WR_ONE_AT_ZERO = 2'd1,
      WR_ZERO_AT_A   = 2'd2,
      WR_SUM         = 2'd3
   } wr_op_type;

   typedef enum logic [2:0] {
      A_HOLD  = 3'd0,
      A_ONE   = 3'd1,
      A_INC   = 3'd2,
      A_DENOM = 3'd3,
      A_ISSUE = 3'd4
   } a_op_type;

   typedef enum logic [1:0] {
      K_HOLD  = 2'd0,
      K_CLEAR = 2'd1,
      K_INC   = 2'd2
   } k_op_type;

   // one control word
   typedef struct packed {
      cond_type  cond;
      step_type  tgt_true;
      step_type  tgt_false;
      logic      req_ready;
      wr_op_type wr_op;
      a_op_type  a_op;
      k_op_type  k_op;
      logic      load_d;
      logic      check;
      logic      rsp_load;
   } ctrl_type;

   // datapath flags for branching
   typedef struct packed {
      logic req_valid;
      logic improper;
      logic clear_end;
      logic kinds_done;
      logic skip;
      logic loop_done;
      logic rsp_free;
   } status_type;

endpackage

// File: hdl/ccw_ram.sv
// ============================================================================
// ccw_ram - generic RAM, one write port and two registered read ports
// Read-first: a read of the address being written returns the old word.
// ============================================================================
module ccw_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: hdl/ccw_sequencer.sv
// ============================================================================
// ccw_sequencer - step counter and control store
// Each step reads one control word; a selected flag picks the next step.
// ============================================================================
module ccw_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  ccw_pkg::status_type status,
   output ccw_pkg::ctrl_type   ctrl
);

   ccw_pkg::step_type step_ff;
   ccw_pkg::step_type step_in;
   logic              cond_hit;

   function automatic ccw_pkg::ctrl_type rom_word(input ccw_pkg::step_type s);
      ccw_pkg::ctrl_type w;
      w.cond      = ccw_pkg::COND_ALWAYS;
      w.tgt_true  = ccw_pkg::STEP_IDLE;
      w.tgt_false = ccw_pkg::STEP_IDLE;
      w.req_ready = 1'b0;
      w.wr_op     = ccw_pkg::WR_NONE;
      w.a_op      = ccw_pkg::A_HOLD;
      w.k_op      = ccw_pkg::K_HOLD;
      w.load_d    = 1'b0;
      w.check     = 1'b0;
      w.rsp_load  = 1'b0;
      case (s)
         ccw_pkg::STEP_IDLE: begin
            w.cond      = ccw_pkg::COND_REQ;
            w.tgt_true  = ccw_pkg::STEP_CHECK;
            w.tgt_false = ccw_pkg::STEP_IDLE;
            w.req_ready = 1'b1;
         end
         ccw_pkg::STEP_CHECK: begin
            w.cond      = ccw_pkg::COND_IMPROPER;
            w.tgt_true  = ccw_pkg::STEP_RESULT;
            w.tgt_false = ccw_pkg::STEP_CLEAR;
            w.wr_op     = ccw_pkg::WR_ONE_AT_ZERO;
            w.a_op      = ccw_pkg::A_ONE;
            w.k_op      = ccw_pkg::K_CLEAR;
            w.check     = 1'b1;
         end
         ccw_pkg::STEP_CLEAR: begin
            w.cond      = ccw_pkg::COND_CLEAR_END;
            w.tgt_true  = ccw_pkg::STEP_KIND;
            w.tgt_false = ccw_pkg::STEP_CLEAR;
            w.wr_op     = ccw_pkg::WR_ZERO_AT_A;
            w.a_op      = ccw_pkg::A_INC;
         end
         ccw_pkg::STEP_KIND: begin
            w.cond      = ccw_pkg::COND_KINDS_DONE;
            w.tgt_true  = ccw_pkg::STEP_FETCH;
            w.tgt_false = ccw_pkg::STEP_SETUP;
            w.load_d    = 1'b1;
         end
         ccw_pkg::STEP_SETUP: begin
            w.cond      = ccw_pkg::COND_SKIP;
            w.tgt_true  = ccw_pkg::STEP_KIND;
            w.tgt_false = ccw_pkg::STEP_LOOP;
            w.a_op      = ccw_pkg::A_DENOM;
            w.k_op      = ccw_pkg::K_INC;
         end
         ccw_pkg::STEP_LOOP: begin
            w.cond      = ccw_pkg::COND_LOOP_DONE;
            w.tgt_true  = ccw_pkg::STEP_KIND;
            w.tgt_false = ccw_pkg::STEP_LOOP;
            w.wr_op     = ccw_pkg::WR_SUM;
            w.a_op      = ccw_pkg::A_ISSUE;
         end
         ccw_pkg::STEP_FETCH: begin
            w.cond      = ccw_pkg::COND_ALWAYS;
            w.tgt_true  = ccw_pkg::STEP_RESULT;
            w.tgt_false = ccw_pkg::STEP_RESULT;
         end
         ccw_pkg::STEP_RESULT: begin
            w.cond      = ccw_pkg::COND_RSP_FREE;
            w.tgt_true  = ccw_pkg::STEP_IDLE;
            w.tgt_false = ccw_pkg::STEP_RESULT;
            w.rsp_load  = 1'b1;
         end
         default: begin
            w.cond = ccw_pkg::COND_ALWAYS;
         end
      endcase
      return w;
   endfunction

   assign ctrl = rom_word(step_ff);

   always_comb begin
      case (ctrl.cond)
         ccw_pkg::COND_REQ:        cond_hit = status.req_valid;
         ccw_pkg::COND_IMPROPER:   cond_hit = status.improper;
         ccw_pkg::COND_CLEAR_END:  cond_hit = status.clear_end;
         ccw_pkg::COND_KINDS_DONE: cond_hit = status.kinds_done;
         ccw_pkg::COND_SKIP:       cond_hit = status.skip;
         ccw_pkg::COND_LOOP_DONE:  cond_hit = status.loop_done;
         ccw_pkg::COND_ALWAYS:     cond_hit = 1'b1;
         ccw_pkg::COND_RSP_FREE:   cond_hit = status.rsp_free;
         default:                  cond_hit = 1'b1;
      endcase
      step_in = cond_hit ? ctrl.tgt_true : ctrl.tgt_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ccw_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ccw_pkg::STEP_IDLE && status.req_valid) |=> step_ff == ccw_pkg::STEP_CHECK)
      else $error("accepted request did not start the check step");

   a_rsp_returns: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ccw_pkg::STEP_RESULT && status.rsp_free) |=> step_ff == ccw_pkg::STEP_IDLE)
      else $error("sequencer did not return to idle after loading a response");

   a_check_branches: assert property (@(posedge clock) disable iff (reset)
      step_ff == ccw_pkg::STEP_CHECK |=>
         (step_ff == ccw_pkg::STEP_RESULT || step_ff == ccw_pkg::STEP_CLEAR))
      else $error("check step did not branch to clear or result");

endmodule

// File: hdl/ccw_datapath.sv
// ============================================================================
// ccw_datapath - denomination registers, ways table and update adder
// Executes the control word: table clear, pipelined update loop, response.
// ============================================================================
module ccw_datapath #(
   parameter int MAX_AMOUNT = 1023,
   parameter int NUM_KINDS  = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic [ccw_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ccw_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [ccw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ccw_pkg::DENOM_W-1:0]         csr_wdata,
   input  ccw_pkg::ctrl_type                   ctrl,
   output ccw_pkg::status_type                 status
);

   localparam int AW    = $clog2(MAX_AMOUNT + 1);
   localparam int CW    = AW + 1;
   localparam int KW    = $clog2(NUM_KINDS + 1);
   localparam int WW    = ccw_pkg::WAYS_W;
   localparam int DEPTH = MAX_AMOUNT + 1;

   logic [ccw_pkg::DENOM_W-1:0]  denom_ff [NUM_KINDS];
   logic [ccw_pkg::AMOUNT_W-1:0] amt_ff;
   logic [ccw_pkg::KINDS_W-1:0]  kinds_ff;
   logic [CW-1:0]                a_ff, a_in;
   logic [KW-1:0]                k_ff, k_in;
   logic [ccw_pkg::DENOM_W-1:0]  d_ff, d_sel;
   logic                         p_ff, p_in;
   logic [AW-1:0]                pa_ff;
   logic                         fwd_ff, fwd_in;
   logic [WW-1:0]                fwd_data_ff;
   logic                         imp_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]                rsp_ways_ff;
   logic                         rsp_imp_ff;

   logic                         req_accept;
   logic                         improper;
   logic                         top_zero;
   logic                         a_in_range;
   logic                         issue;
   logic [CW-1:0]                a_minus_d;
   logic [AW-1:0]                amt_addr;
   logic [AW-1:0]                rd_addr_a, rd_addr_b;
   logic [WW-1:0]                rd_data_a, rd_data_b;
   logic [WW-1:0]                lag_ways;
   logic [WW:0]                  sum_wide;
   logic [WW-1:0]                sum_sat;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [WW-1:0]                wr_data;
   logic                         rsp_free;
   logic                         rsp_load;

   assign req_accept = req_tvalid && ctrl.req_ready;

   // proper-request check on the held request
   always_comb begin
      top_zero = 1'b0;
      for (int i = 0; i < NUM_KINDS; i++) begin
         if (32'(kinds_ff) == i + 1 && denom_ff[i] == '0) begin
            top_zero = 1'b1;
         end
      end
      improper = (amt_ff == '0) || (kinds_ff == '0) ||
                 (32'(kinds_ff) > NUM_KINDS) || (32'(amt_ff) > MAX_AMOUNT) || top_zero;
   end

   // denomination of the current kind
   always_comb begin
      d_sel = '0;
      for (int i = 0; i < NUM_KINDS; i++) begin
         if (32'(k_ff) == i) begin
            d_sel = denom_ff[i];
         end
      end
   end

   assign amt_addr   = AW'(32'(amt_ff));
   assign a_in_range = 32'(a_ff) <= 32'(amt_ff);
   assign issue      = (ctrl.a_op == ccw_pkg::A_ISSUE) && a_in_range;
   assign a_minus_d  = CW'(32'(a_ff) - 32'(d_ff));

   assign rd_addr_a = issue ? a_ff[AW-1:0] : amt_addr;
   assign rd_addr_b = a_minus_d[AW-1:0];

   // ways[a] + ways[a-d], the lagging term forwarded when written last cycle
   assign lag_ways = fwd_ff ? fwd_data_ff : rd_data_b;
   assign sum_wide = {1'b0, rd_data_a} + {1'b0, lag_ways};
   assign sum_sat  = sum_wide[WW] ? {WW{1'b1}} : sum_wide[WW-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = a_ff[AW-1:0];
      wr_data = '0;
      case (ctrl.wr_op)
         ccw_pkg::WR_NONE: begin
            wr_en = 1'b0;
         end
         ccw_pkg::WR_ONE_AT_ZERO: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = WW'(1);
         end
         ccw_pkg::WR_ZERO_AT_A: begin
            wr_en   = 1'b1;
            wr_addr = a_ff[AW-1:0];
         end
         ccw_pkg::WR_SUM: begin
            wr_en   = p_ff;
            wr_addr = pa_ff;
            wr_data = sum_sat;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign p_in   = issue;
   assign fwd_in = issue && p_ff && (rd_addr_b == pa_ff);

   always_comb begin
      case (ctrl.a_op)
         ccw_pkg::A_HOLD:  a_in = a_ff;
         ccw_pkg::A_ONE:   a_in = CW'(1);
         ccw_pkg::A_INC:   a_in = a_ff + CW'(1);
         ccw_pkg::A_DENOM: a_in = CW'(d_ff);
         ccw_pkg::A_ISSUE: a_in = issue ? a_ff + CW'(1) : a_ff;
         default:          a_in = a_ff;
      endcase
      case (ctrl.k_op)
         ccw_pkg::K_HOLD:  k_in = k_ff;
         ccw_pkg::K_CLEAR: k_in = '0;
         ccw_pkg::K_INC:   k_in = k_ff + KW'(1);
         default:          k_in = k_ff;
      endcase
   end

   // response register
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_load     = ctrl.rsp_load && rsp_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   ccw_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_ways_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // control registers and denominations
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KINDS; i++) begin
            denom_ff[i] <= ccw_pkg::DENOM_RESET[i];
         end
         k_ff         <= '0;
         p_ff         <= 1'b0;
         fwd_ff       <= 1'b0;
         imp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            for (int i = 0; i < NUM_KINDS; i++) begin
               if (csr_index == ccw_pkg::CSR_IDX_W'(i)) begin
                  denom_ff[i] <= csr_wdata;
               end
            end
         end
         k_ff         <= k_in;
         p_ff         <= p_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.check) begin
            imp_ff <= improper;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         amt_ff   <= req_tdata[ccw_pkg::REQ_AMOUNT_LSB +: ccw_pkg::AMOUNT_W];
         kinds_ff <= req_tdata[ccw_pkg::REQ_KINDS_LSB +: ccw_pkg::KINDS_W];
      end
      a_ff        <= a_in;
      pa_ff       <= a_ff[AW-1:0];
      fwd_data_ff <= sum_sat;
      if (ctrl.load_d) begin
         d_ff <= d_sel;
      end
      if (rsp_load) begin
         rsp_ways_ff <= imp_ff ? '0 : rd_data_a;
         rsp_imp_ff  <= imp_ff;
      end
   end

   assign status.req_valid  = req_tvalid;
   assign status.improper   = improper;
   assign status.clear_end  = 32'(a_ff) == 32'(amt_ff);
   assign status.kinds_done = 32'(k_ff) == 32'(kinds_ff);
   assign status.skip       = (d_ff == '0) || (32'(d_ff) > 32'(amt_ff));
   assign status.loop_done  = !a_in_range && !p_ff;
   assign status.rsp_free   = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ccw_pkg::RSP_TDATA_W'(rsp_ways_ff);
   assign rsp_tuser  = rsp_imp_ff;

   a_improper_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tdata == '0)
      else $error("improper response carries a non-zero count");

   a_fwd_origin: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> $past(p_ff) && $past(issue))
      else $error("forwarded sum without a write in flight");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      p_ff |-> 32'(pa_ff) <= 32'(amt_ff))
      else $error("update write beyond the requested amount");

endmodule

// File: hdl/coin_change_way_counter_top.sv
// ============================================================================
// coin_change_way_counter_top - count the ways to make an amount from coins
// Bottom-up table over amounts, driven by a small microcoded sequencer.
// ============================================================================
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  req      | req_tvalid / req_tready  | tdata: amount[9:0], coin_kinds[17:10]
//  rsp      | rsp_tvalid / rsp_tready  | tdata: ways[47:0]; tuser: improper
//  csr      | csr_we (no back-pressure)| csr_index selects denom, csr_wdata[9:0]
//
//  An improper request goes from the check step straight to the result step.
//  A proper one clears the table entries up to the amount, then runs an update
//  pass over the amounts for each usable kind and skips each kind whose
//  denomination is zero or above the amount. The single write port of the ways
//  table takes one clear or one saturating update per cycle.
//  Reset (synchronous, active high) restores the default denominations and
//  returns the sequencer to idle; the table needs no clearing pass since each
//  request rewrites every entry it reads.
//  A request is taken only in idle; a finished response waits in its output
//  register while the next request is accepted and worked on.
//
module coin_change_way_counter_top #(
   parameter int MAX_AMOUNT = 1023,
   parameter int NUM_KINDS  = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ccw_pkg::REQ_TDATA_W-1:0] req_tdata,  // amount[9:0], coin_kinds[17:10]
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ccw_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // ways[47:0]
   output logic                            rsp_tuser,  // improper[0]
   // configuration writes
   input  logic                            csr_we,
   input  logic [ccw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ccw_pkg::DENOM_W-1:0]     csr_wdata
);

   ccw_pkg::ctrl_type   ctrl;
   ccw_pkg::status_type status;

   // step counter and control store: picks one control word each cycle
   ccw_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // table, adder and response register under that control word
   ccw_datapath #(
      .MAX_AMOUNT (MAX_AMOUNT),
      .NUM_KINDS  (NUM_KINDS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ctrl       (ctrl),
      .status     (status)
   );

   // ready only on the idle step of the program
   assign req_tready = ctrl.req_ready;

endmodule
